// File: hw/rtl/rthp_pkg.sv
package rthp_pkg;

    // hue field, hue quotient and hue offset widths
    localparam int HUE_BITS     = 9;
    localparam int HUE_QBITS    = 7;
    localparam int HUE_OFF_BITS = 10;

    // sector offsets: base + 300, since the divider returns
    // floor(60 * (plus - minus + d) / d), which is biased by 60
    localparam logic [HUE_OFF_BITS-1:0] HUE_OFF_RED   = 10'd300;
    localparam logic [HUE_OFF_BITS-1:0] HUE_OFF_GREEN = 10'd420;
    localparam logic [HUE_OFF_BITS-1:0] HUE_OFF_BLUE  = 10'd540;
    localparam logic [HUE_OFF_BITS-1:0] HUE_WRAP      = 10'd360;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        sector_t sector;
        logic    grey;
    } hue_tag_t;

endpackage

// File: hw/rtl/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, fully pipelined.
// Pipeline: start is taken into the front end's capture, max/min/sector and numerator stages, then
//   passes through the divider stages and the output register, which drives done.
// Throughput: one item per clock; busy is tied low, the receiver cannot stall.
// Latency is set mostly by the two dividers, one quotient bit per stage up to the quotient width.
// Reset (rst_n low, async) clears all valid bits; payload registers are not reset.
module rgb_to_hsv_pixel
    import rthp_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    output logic                    done,
    output logic [HUE_BITS-1:0]     hue,
    output logic [CHANNEL_BITS-1:0] saturation,
    output logic [CHANNEL_BITS-1:0] brightness
);

    localparam int N = CHANNEL_BITS;
    // both dividers run the same depth so their items stay aligned
    localparam int DIV_STAGES = (N > HUE_QBITS) ? N : HUE_QBITS;
    localparam int TAG_W      = $bits(hue_tag_t);

    // front end: capture, max/min/sector, numerator build (3 stages)
    logic                   f_valid;
    logic [2*N-1:0]         f_sat_num;
    logic [N-1:0]           f_sat_den, f_hue_den;
    logic [N+HUE_QBITS-1:0] f_hue_num;
    hue_tag_t               f_tag;

    // divider outputs
    logic                 sd_valid, hd_valid;
    logic [N-1:0]         sd_quo, sd_hi;
    logic [HUE_QBITS-1:0] hd_quo;
    logic [TAG_W-1:0]     hd_tag_bits;
    hue_tag_t             hd_tag;

    // output stage
    logic                    done_reg;
    logic [HUE_BITS-1:0]     hue_reg, hue_next;
    logic [N-1:0]            sat_reg, sat_next;
    logic [N-1:0]            bright_reg;
    logic [HUE_OFF_BITS-1:0] hue_off, hue_sum, hue_wrapped;

    // never stalls
    assign busy = 1'b0;

    rthp_front #(
        .CHANNEL_BITS(N)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .out_valid(f_valid),
        .sat_num  (f_sat_num),
        .sat_den  (f_sat_den),
        .hue_num  (f_hue_num),
        .hue_den  (f_hue_den),
        .hue_tag  (f_tag)
    );

    // saturation: floor(CMAX * d / max); max rides along as the tag
    rthp_div #(
        .DEN_W (N),
        .Q_W   (N),
        .STAGES(DIV_STAGES),
        .TAG_W (N)
    ) u_sat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .num      (f_sat_num),
        .den      (f_sat_den),
        .tag      (f_sat_den),
        .out_valid(sd_valid),
        .quo      (sd_quo),
        .out_tag  (sd_hi)
    );

    // hue: floor(60 * (plus - minus + d) / d), in 0..120
    rthp_div #(
        .DEN_W (N),
        .Q_W   (HUE_QBITS),
        .STAGES(DIV_STAGES),
        .TAG_W (TAG_W)
    ) u_hue_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .num      (f_hue_num),
        .den      (f_hue_den),
        .tag      (f_tag),
        .out_valid(hd_valid),
        .quo      (hd_quo),
        .out_tag  (hd_tag_bits)
    );

    assign hd_tag = hue_tag_t'(hd_tag_bits);

    // sector offset plus quotient lands in 300..660: one wrap at most
    always_comb
    begin
        unique case (hd_tag.sector)
            SECTOR_RED:   hue_off = HUE_OFF_RED;
            SECTOR_GREEN: hue_off = HUE_OFF_GREEN;
            SECTOR_BLUE:  hue_off = HUE_OFF_BLUE;
            default:      hue_off = HUE_OFF_RED;
        endcase
        hue_sum     = hue_off + HUE_OFF_BITS'(hd_quo);
        hue_wrapped = (hue_sum >= HUE_WRAP) ? (hue_sum - HUE_WRAP) : hue_sum;
        // grey (and black) pixels: divisor was zero, force hue and saturation to 0
        if (hd_tag.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_wrapped[HUE_BITS-1:0];
            sat_next = sd_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sd_valid && hd_valid;
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= sd_hi;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

// File: hw/rtl/rthp_front.sv
module rthp_front
    import rthp_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [CHANNEL_BITS-1:0]        red,
    input  logic [CHANNEL_BITS-1:0]        green,
    input  logic [CHANNEL_BITS-1:0]        blue,
    output logic                           out_valid,
    output logic [2*CHANNEL_BITS-1:0]      sat_num,
    output logic [CHANNEL_BITS-1:0]        sat_den,
    output logic [CHANNEL_BITS+HUE_QBITS-1:0] hue_num,
    output logic [CHANNEL_BITS-1:0]        hue_den,
    output hue_tag_t                       hue_tag
);

    localparam int N = CHANNEL_BITS;

    // stage A: input capture
    logic         va_reg;
    logic [N-1:0] red_reg, green_reg, blue_reg;

    // stage B: max / min / sector
    logic         vb_reg;
    logic [N-1:0] hi_reg, d_reg, plus_reg, minus_reg;
    sector_t      sector_reg;
    logic [N-1:0] hi_next, lo_next, rg_hi, rg_lo, plus_next, minus_next;
    sector_t      sector_next;

    // stage C: numerators
    logic                   vc_reg;
    logic [2*N-1:0]         sat_num_reg;
    logic [N-1:0]           sat_den_reg, hue_den_reg;
    logic [N+HUE_QBITS-1:0] hue_num_reg;
    hue_tag_t               tag_reg;
    logic [N:0]             x_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red;
        green_reg <= green;
        blue_reg  <= blue;
    end

    always_comb
    begin
        rg_hi   = (green_reg > red_reg) ? green_reg : red_reg;
        rg_lo   = (green_reg < red_reg) ? green_reg : red_reg;
        hi_next = (blue_reg > rg_hi) ? blue_reg : rg_hi;
        lo_next = (blue_reg < rg_lo) ? blue_reg : rg_lo;
        // later channel wins ties
        priority if (hi_next == blue_reg)
        begin
            sector_next = SECTOR_BLUE;
            plus_next   = red_reg;
            minus_next  = green_reg;
        end
        else if (hi_next == green_reg)
        begin
            sector_next = SECTOR_GREEN;
            plus_next   = blue_reg;
            minus_next  = red_reg;
        end
        else
        begin
            sector_next = SECTOR_RED;
            plus_next   = green_reg;
            minus_next  = blue_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        d_reg      <= hi_next - lo_next;
        plus_reg   <= plus_next;
        minus_reg  <= minus_next;
        sector_reg <= sector_next;
    end

    // plus - minus lies in [-d, d], so x = plus - minus + d lies in [0, 2d]
    assign x_next = {1'b0, plus_reg} + {1'b0, d_reg} - {1'b0, minus_reg};

    always_ff @(posedge clk)
    begin
        sat_num_reg    <= {d_reg, {N{1'b0}}} - {{N{1'b0}}, d_reg};     // CMAX * d
        sat_den_reg    <= hi_reg;
        hue_num_reg    <= {x_next, 6'b0} - {4'b0, x_next, 2'b0};      // 60 * x
        hue_den_reg    <= d_reg;
        tag_reg.sector <= sector_reg;
        tag_reg.grey   <= (d_reg == '0);
    end

    assign out_valid = vc_reg;
    assign sat_num   = sat_num_reg;
    assign sat_den   = sat_den_reg;
    assign hue_num   = hue_num_reg;
    assign hue_den   = hue_den_reg;
    assign hue_tag   = tag_reg;

endmodule

// File: hw/rtl/rthp_div.sv
module rthp_div #(
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,
    parameter int STAGES = 8,
    parameter int TAG_W  = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [DEN_W+Q_W-1:0]   num,
    input  logic [DEN_W-1:0]       den,
    input  logic [TAG_W-1:0]       tag,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quo,
    output logic [TAG_W-1:0]       out_tag
);

    // restoring divider, one quotient bit per stage; the quotient must
    // fit Q_W bits (upper DEN_W numerator bits below den). Stages past
    // Q_W only delay.
    logic             p_v [0:STAGES];
    logic [DEN_W-1:0] p_r [0:STAGES];
    logic [Q_W-1:0]   p_n [0:STAGES];
    logic [Q_W-1:0]   p_q [0:STAGES];
    logic [DEN_W-1:0] p_d [0:STAGES];
    logic [TAG_W-1:0] p_t [0:STAGES];

    assign p_v[0] = in_valid;
    assign p_r[0] = num[DEN_W+Q_W-1:Q_W];
    assign p_n[0] = num[Q_W-1:0];
    assign p_q[0] = '0;
    assign p_d[0] = den;
    assign p_t[0] = tag;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic             v_reg;
        logic [DEN_W-1:0] r_reg, r_next, d_reg;
        logic [Q_W-1:0]   n_reg, n_next, q_reg, q_next;
        logic [TAG_W-1:0] t_reg;

        if (s < Q_W)
        begin : g_step
            logic [DEN_W:0] trial;
            always_comb
            begin
                trial  = {p_r[s], p_n[s][Q_W-1]};
                n_next = {p_n[s][Q_W-2:0], 1'b0};
                if (trial >= {1'b0, p_d[s]})
                begin
                    r_next = DEN_W'(trial - {1'b0, p_d[s]});
                    q_next = {p_q[s][Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = trial[DEN_W-1:0];
                    q_next = {p_q[s][Q_W-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_hold
            always_comb
            begin
                r_next = p_r[s];
                n_next = p_n[s];
                q_next = p_q[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= p_v[s];
        end

        always_ff @(posedge clk)
        begin
            r_reg <= r_next;
            n_reg <= n_next;
            q_reg <= q_next;
            d_reg <= p_d[s];
            t_reg <= p_t[s];
        end

        assign p_v[s+1] = v_reg;
        assign p_r[s+1] = r_reg;
        assign p_n[s+1] = n_reg;
        assign p_q[s+1] = q_reg;
        assign p_d[s+1] = d_reg;
        assign p_t[s+1] = t_reg;
    end

    assign out_valid = p_v[STAGES];
    assign quo       = p_q[STAGES];
    assign out_tag   = p_t[STAGES];

endmodule

// File: hw/rtl/rthp_chk.sv
module rthp_chk
    import rthp_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [CHANNEL_BITS-1:0] red,
    input logic [CHANNEL_BITS-1:0] green,
    input logic [CHANNEL_BITS-1:0] blue,
    input logic                    done,
    input logic [HUE_BITS-1:0]     hue,
    input logic [CHANNEL_BITS-1:0] saturation,
    input logic [CHANNEL_BITS-1:0] brightness
);

    localparam int DIV_STAGES = (CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS;
    // edges from the accepting edge to the edge that takes the result
    localparam int LAT   = DIV_STAGES + 4;
    localparam int CNT_W = $clog2(LAT + 1);

    // cycles since reset, saturating at LAT
    logic [CNT_W-1:0] warm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            warm_reg <= '0;
        else if (warm_reg != CNT_W'(LAT))
            warm_reg <= warm_reg + 1'b1;
    end

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == CNT_W'(LAT)) |-> (done == $past(start && !busy, LAT)))
        else $error("result strobe does not follow accepted item at fixed latency");

    a_no_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy asserted on a pipeline that never stalls");

    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue < HUE_BITS'(HUE_WRAP)))
        else $error("hue out of range");

    a_black : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (brightness == '0)) |-> ((saturation == '0) && (hue == '0)))
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel rthp_chk #(
    .CHANNEL_BITS(CHANNEL_BITS)
) u_rthp_chk (.*);
